// ===== sv/bit_field_store_core_macros.svh =====
// Assertion helpers for the bit field store. Each use expects clk_i and rst_ni in scope.
`ifndef BIT_FIELD_STORE_CORE_MACROS_SVH
`define BIT_FIELD_STORE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define BFS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define BFS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bfs_pkg.sv =====
package bfs_pkg;

  localparam int unsigned START_W = 13;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned OFF_W = 6;
  localparam int unsigned MAX_FIELD_BITS = 64;
  localparam int unsigned STORE_BYTES_DEF = 1024;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LO   = 4'b0010,
    ST_HI   = 4'b0100,
    ST_FIN  = 4'b1000
  } bfs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mem_lo;
    logic mem_hi;
    logic load_out;
  } bfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_write;
    logic err;
    logic need_hi;
    logic out_free;
  } bfs_sts_t;

  // Mask with the low cnt bits set; counts of 64 and above give all ones.
  function automatic logic [DATA_W-1:0] low_mask(input logic [COUNT_W-1:0] cnt);
    logic [DATA_W-1:0] m;
    if (cnt >= COUNT_W'(DATA_W)) begin
      m = '1;
    end else begin
      m = (DATA_W'(1) << cnt) - DATA_W'(1);
    end
    return m;
  endfunction

endpackage

// ===== sv/bfs_if.sv =====
interface bfs_req_if;
  import bfs_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [START_W-1:0] start_bit;
  logic [COUNT_W-1:0] field_bits;
  logic [DATA_W-1:0]  write_value;

  modport source (output valid, kind, start_bit, field_bits, write_value, input ready);
  modport sink (input valid, kind, start_bit, field_bits, write_value, output ready);
endinterface

interface bfs_rsp_if;
  import bfs_pkg::*;

  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_value;
  logic [COUNT_W-1:0] bits_done;
  logic               range_error;

  modport source (output valid, read_value, bits_done, range_error, input ready);
  modport sink (input valid, read_value, bits_done, range_error, output ready);
endinterface

// ===== sv/bfs_ctrl.sv =====
module bfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bfs_pkg::bfs_sts_t sts_i,
  output bfs_pkg::bfs_cmd_t cmd_o
);
  import bfs_pkg::*;

  bfs_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = ST_LO;
        end
      end
      ST_LO: begin
        // A refused request never touches the memory.
        if (sts_i.err) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.mem_lo = 1'b1;
          if (sts_i.is_write && !sts_i.need_hi) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_HI;
          end
        end
      end
      ST_HI: begin
        cmd_o.mem_hi = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/bfs_dp.sv =====
module bfs_dp #(
  parameter int unsigned STORE_BYTES = bfs_pkg::STORE_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bfs_pkg::bfs_cmd_t           cmd_i,
  output bfs_pkg::bfs_sts_t           sts_o,
  input  logic                        kind_i,
  input  logic [bfs_pkg::START_W-1:0] start_bit_i,
  input  logic [bfs_pkg::COUNT_W-1:0] field_bits_i,
  input  logic [bfs_pkg::DATA_W-1:0]  write_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bfs_pkg::DATA_W-1:0]  read_value_o,
  output logic [bfs_pkg::COUNT_W-1:0] bits_done_o,
  output logic                        range_error_o
);
  import bfs_pkg::*;

  localparam int unsigned WORDS = (STORE_BYTES + 7) / 8;
  localparam int unsigned AW = $clog2(WORDS);
  localparam int unsigned TOTAL_BITS = STORE_BYTES * 8;

  logic               kind_q;
  logic [START_W-1:0] start_q;
  logic [COUNT_W-1:0] cnt_q;
  logic [DATA_W-1:0]  wval_q;

  logic [WORD_BITS-1:0] mem_q [WORDS];
  logic [WORD_BITS-1:0] rd_q;
  logic [WORD_BITS-1:0] lo_q;

  logic                 out_valid_q;
  logic [DATA_W-1:0]    read_value_q;
  logic [COUNT_W-1:0]   bits_done_q;
  logic                 range_error_q;

  logic [OFF_W-1:0]       off;
  logic [31:0]            word_num;
  logic [31:0]            word_nxt;
  logic [AW-1:0]          addr_lo;
  logic [AW-1:0]          addr_hi;
  logic [DATA_W-1:0]      fmask;
  logic [2*WORD_BITS-1:0] wide_data;
  logic [2*WORD_BITS-1:0] wide_mask;
  logic [2*WORD_BITS-1:0] gathered;
  logic                   err;
  logic                   need_hi;
  logic                   is_write;
  logic                   mem_we;
  logic                   mem_re;
  logic [AW-1:0]          waddr;
  logic [WORD_BITS-1:0]   wdata;
  logic [WORD_BITS-1:0]   wmask;
  logic [AW-1:0]          raddr;

  always_comb begin
    is_write = (kind_q == KIND_WRITE);
    off = start_q[OFF_W-1:0];
    word_num = 32'(start_q >> OFF_W);
    word_nxt = word_num + 32'd1;
    addr_lo = word_num[AW-1:0];
    addr_hi = word_nxt[AW-1:0];
    err = (32'(cnt_q) > MAX_FIELD_BITS) ||
          ((32'(start_q) + 32'(cnt_q)) > TOTAL_BITS);
    need_hi = ({2'b00, off} + {1'b0, cnt_q}) > 8'(WORD_BITS);
    fmask = low_mask(cnt_q);
    wide_data = {{WORD_BITS{1'b0}}, wval_q & fmask} << off;
    wide_mask = {{WORD_BITS{1'b0}}, fmask} << off;
    gathered = {rd_q, lo_q} >> off;

    mem_we = is_write && (cmd_i.mem_lo || (cmd_i.mem_hi && need_hi));
    mem_re = !is_write && (cmd_i.mem_lo || cmd_i.mem_hi);
    waddr = cmd_i.mem_hi ? addr_hi : addr_lo;
    wdata = cmd_i.mem_hi ? wide_data[2*WORD_BITS-1:WORD_BITS] : wide_data[WORD_BITS-1:0];
    wmask = cmd_i.mem_hi ? wide_mask[2*WORD_BITS-1:WORD_BITS] : wide_mask[WORD_BITS-1:0];
    raddr = cmd_i.mem_hi ? addr_hi : addr_lo;
  end

  always_comb begin
    sts_o.is_write = is_write;
    sts_o.err = err;
    sts_o.need_hi = need_hi;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      start_q <= start_bit_i;
      cnt_q <= field_bits_i;
      wval_q <= write_value_i;
    end
  end

  // Bit-masked write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        if (wmask[b]) begin
          mem_q[waddr][b] <= wdata[b];
        end
      end
    end
    if (mem_re) begin
      rd_q <= mem_q[raddr];
    end
    if (mem_re && cmd_i.mem_hi) begin
      lo_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (err) begin
        read_value_q <= '0;
        bits_done_q <= '0;
        range_error_q <= 1'b1;
      end else begin
        read_value_q <= is_write ? '0 : (gathered[DATA_W-1:0] & fmask);
        bits_done_q <= cnt_q;
        range_error_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_value_o = read_value_q;
  assign bits_done_o = bits_done_q;
  assign range_error_o = range_error_q;

endmodule

// ===== sv/bit_field_store_core.sv =====
// Bit field store: a STORE_BYTES-byte store, kept as 64-bit words in a single-port-write,
// single-port-read memory, that serves field reads and field writes of 0 to 64 bits at any
// bit offset, packed LSB-first (field bit i is store bit start_bit+i, store bit k sits in
// byte k/8 at position k%8). Each request gives exactly one response: a write returns the
// count, a read returns the gathered value (zero above the count) and the count. A field
// that runs past the end of the store, or that is wider than 64 bits, is refused with
// range_error set, a count of zero and the store untouched. The block works on one request
// at a time. After a request is accepted, the controller steps through ST_LO, which accesses
// the low memory word, then ST_HI, which accesses the high word, for a write that straddles
// two words and for any read (a read always fetches both words), then ST_FIN, which loads
// the response register. A refused request goes from ST_LO straight to ST_FIN and never
// touches the memory. Each memory word is touched in its own cycle on the one read or write
// port. A response that is still waiting to be taken holds the request in its last cycle
// until the response register is free. The next request is accepted the cycle after the
// response register is loaded, while that response may still wait to be taken. Store
// contents are undefined until written; reading bits that were never written returns
// arbitrary data in those bit positions.
module bit_field_store_core #(
  parameter int unsigned STORE_BYTES = bfs_pkg::STORE_BYTES_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  bfs_req_if.sink   req_i,
  bfs_rsp_if.source rsp_o
);
  import bfs_pkg::*;

  bfs_cmd_t cmd;
  bfs_sts_t sts;
  logic     in_ready;

  // The controller sequences each request through the memory word accesses.
  bfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the request, the memory and the response register.
  bfs_dp #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (req_i.kind),
    .start_bit_i   (req_i.start_bit),
    .field_bits_i  (req_i.field_bits),
    .write_value_i (req_i.write_value),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .read_value_o  (rsp_o.read_value),
    .bits_done_o   (rsp_o.bits_done),
    .range_error_o (rsp_o.range_error)
  );

  assign req_i.ready = in_ready;

`include "bit_field_store_core_macros.svh"

  // Once a request is taken the block must stop accepting until it is finished.
  `BFS_ASSERT_NXT(a_busy_after_accept, req_i.valid && req_i.ready, !req_i.ready, "accepted twice")
  // A refused request must never reach the memory.
  `BFS_ASSERT_IMP(a_no_mem_on_err, cmd.mem_lo || cmd.mem_hi, !sts.err, "memory on refused request")
  // Loading the response register must present a response on the next cycle.
  `BFS_ASSERT_NXT(a_load_shows_rsp, cmd.load_out, rsp_o.valid, "loaded response not presented")
  // The response register is loaded only when it is free.
  `BFS_ASSERT_IMP(a_load_when_free, cmd.load_out, !rsp_o.valid || rsp_o.ready, "response lost")

endmodule
